[sv/bms_pkg.sv]
// Shared types, register codes and saturating helpers for the box motion step.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bms_pkg;

   localparam int PIPE_DEPTH   = 10;
   localparam int INTEG_STAGES = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_ACCEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd3;

   localparam logic [16:0]        ONE_Q16 = 17'h10000;
   localparam logic signed [63:0] RND16   = 64'sd32768;
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [15:0] gravity_accel;
      logic [15:0]        time_step;
      logic [11:0]        screen_width;
      logic [11:0]        screen_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gravity_accel: 16'sd2509,
      time_step:     16'd1092,
      screen_width:  12'd800,
      screen_height: 12'd600
   };

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [27:0]        box_width;
      logic [27:0]        box_height;
      logic [16:0]        restitution;
      logic [16:0]        friction;
      logic               pinned;
   } box_in_type;

   // Result of the integration half, handed to the collision half.
   typedef struct packed {
      box_in_type         item;
      logic signed [17:0] nrest;     // minus the clamped restitution
      logic [16:0]        onemf;     // one minus the clamped friction
      logic signed [31:0] px1;
      logic signed [31:0] py1;
      logic signed [31:0] vy1;
      logic               at_left;   // px1 at or left of zero
      logic               at_right;  // right edge at or past the wall
      logic signed [31:0] wall_x;    // x that puts the right edge on the wall
   } integ_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
   } box_out_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > S32_MAX) begin
         r = S32_MAX[31:0];
      end else if (x < S32_MIN) begin
         r = S32_MIN[31:0];
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Round a Q.32 product to Q.16 (ties toward +infinity) and saturate.
   function automatic logic signed [31:0] round16_sat(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = (p + RND16) >>> 16;
      return sat32(s);
   endfunction

endpackage

`default_nettype wire

[sv/box_motion_step.sv]
// One Euler physics step per box with floor and side wall bounce. A box may enter
// on every cycle unless a stalled output holds back a full pipeline; the depth is set by
// the chain of five dependent multiplies (gravity times time step, the scaling
// to pixels, vertical velocity times time step, the floor bounce and then the
// wall bounce), each with its own stage, and the adds and tests between them.
// Configuration registers are written through the csr_ port and must only
// change while no box is in flight. Depends on bms_pkg, bms_pipe_ctrl,
// bms_integrate and bms_collide.
`default_nettype none

module box_motion_step
   import bms_pkg::*;
#(
   parameter int FRAC_BITS        = 16,
   parameter int PIXELS_PER_METRE = 100
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // pos_x, pos_y, vel_x, vel_y, box_width, box_height, restitution,
   // friction, then zero fill
   input  wire logic [223:0]          req_tdata,
   // pinned
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
   output logic [127:0]               rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRAVITY_ACCEL: cfg_in.gravity_accel = csr_wdata;
            CSR_TIME_STEP:     cfg_in.time_step     = csr_wdata;
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[11:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[11:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   box_in_type req_item;

   always_comb begin
      req_item.pos_x       = req_tdata[31:0];
      req_item.pos_y       = req_tdata[63:32];
      req_item.vel_x       = req_tdata[95:64];
      req_item.vel_y       = req_tdata[127:96];
      req_item.box_width   = req_tdata[155:128];
      req_item.box_height  = req_tdata[183:156];
      req_item.restitution = req_tdata[200:184];
      req_item.friction    = req_tdata[217:201];
      req_item.pinned      = req_tuser;
   end

   logic [PIPE_DEPTH-1:0] stage_en;
   logic [PIPE_DEPTH-1:0] stage_valid;

   bms_pipe_ctrl #(
      .DEPTH (PIPE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .out_ready   (rsp_tready),
      .in_ready    (req_tready),
      .stage_en    (stage_en),
      .stage_valid (stage_valid)
   );

   integ_type   integ;
   box_out_type rsp_item;

   bms_integrate #(
      .FRAC_BITS        (FRAC_BITS),
      .PIXELS_PER_METRE (PIXELS_PER_METRE)
   ) u_integrate (
      .clock    (clock),
      .cfg      (cfg_ff),
      .stage_en (stage_en[INTEG_STAGES-1:0]),
      .in_item  (req_item),
      .out_data (integ)
   );

   bms_collide #(
      .FRAC_BITS (FRAC_BITS)
   ) u_collide (
      .clock    (clock),
      .cfg      (cfg_ff),
      .stage_en (stage_en[PIPE_DEPTH-1:INTEG_STAGES]),
      .in_data  (integ),
      .out_data (rsp_item)
   );

   assign rsp_tvalid = stage_valid[PIPE_DEPTH-1];
   assign rsp_tdata  = {rsp_item.new_vel_y, rsp_item.new_vel_x,
                        rsp_item.new_pos_y, rsp_item.new_pos_x};

   // A full pipeline with a stalled output cannot take another transfer.
   assert property (@(posedge clock) disable iff (reset)
      (&stage_valid) && !rsp_tready |-> !req_tready)
      else $error("input accepted while the pipeline is full and stalled");

   // An empty pipeline always accepts.
   assert property (@(posedge clock) disable iff (reset)
      stage_valid == '0 |-> req_tready)
      else $error("empty pipeline refuses input");

   // Reset brings the registers back to their defaults.
   assert property (@(posedge clock)
      reset |=> cfg_ff == CFG_RESET)
      else $error("configuration registers not at reset values");

endmodule

`default_nettype wire

[sv/bms_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the box motion pipeline.
// Bubbles collapse, so a stalled output only holds back stages that are full.
`default_nettype none

module bms_pipe_ctrl
   import bms_pkg::*;
#(
   parameter int DEPTH = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic             out_ready,
   output logic                  in_ready,
   output logic [DEPTH-1:0]      stage_en,
   output logic [DEPTH-1:0]      stage_valid
);

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   always_comb begin
      stage_en[DEPTH-1] = !valid_ff[DEPTH-1] || out_ready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready    = stage_en[0];
   assign stage_valid = valid_ff;

endmodule

`default_nettype wire

[sv/bms_integrate.sv]
// Stages one to five: gravity into vertical velocity, Euler position update
// and the side wall tests. Depends on bms_pkg.
`default_nettype none

module bms_integrate
   import bms_pkg::*;
#(
   parameter int FRAC_BITS        = 16,
   parameter int PIXELS_PER_METRE = 100
) (
   input  wire logic                    clock,
   input  wire cfg_type                 cfg,
   input  wire logic [INTEG_STAGES-1:0] stage_en,
   input  wire box_in_type              in_item,
   output integ_type                    out_data
);

   localparam int SHIFT_G = 24 - FRAC_BITS;
   localparam int PPM_W   = $clog2(PIXELS_PER_METRE + 1);
   localparam int GP_W    = 33;
   localparam int DVP_W   = GP_W + PPM_W + 1;
   localparam logic [PPM_W-1:0]   PPM_U = PPM_W'(PIXELS_PER_METRE);
   localparam logic signed [63:0] RND_G = 64'((2 ** SHIFT_G) / 2);

   // Stage 1: gravity times time step, vel_x times time step, factor clamps.
   box_in_type             s1_item_ff;
   logic signed [GP_W-1:0] s1_gp_ff,    s1_gp_in;
   logic signed [48:0]     s1_vxdt_ff,  s1_vxdt_in;
   logic signed [17:0]     s1_nrest_ff, s1_nrest_in;
   logic [16:0]            s1_onemf_ff, s1_onemf_in;
   logic [16:0]            rest_c, fric_c;

   always_comb begin
      rest_c      = (in_item.restitution > ONE_Q16) ? ONE_Q16 : in_item.restitution;
      fric_c      = (in_item.friction > ONE_Q16) ? ONE_Q16 : in_item.friction;
      s1_gp_in    = cfg.gravity_accel * $signed({1'b0, cfg.time_step});
      s1_vxdt_in  = in_item.vel_x * $signed({1'b0, cfg.time_step});
      s1_nrest_in = -$signed({1'b0, rest_c});
      s1_onemf_in = ONE_Q16 - fric_c;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_item_ff  <= in_item;
         s1_gp_ff    <= s1_gp_in;
         s1_vxdt_ff  <= s1_vxdt_in;
         s1_nrest_ff <= s1_nrest_in;
         s1_onemf_ff <= s1_onemf_in;
      end
   end

   // Stage 2: scale gravity to pixels, new x position.
   box_in_type              s2_item_ff;
   logic signed [17:0]      s2_nrest_ff;
   logic [16:0]             s2_onemf_ff;
   logic signed [DVP_W-1:0] s2_dvp_ff, s2_dvp_in;
   logic signed [31:0]      s2_px1_ff, s2_px1_in;
   logic signed [63:0]      pxs;

   always_comb begin
      s2_dvp_in = s1_gp_ff * $signed({1'b0, PPM_U});
      // Rounding of the step is folded into the position add.
      pxs       = (64'(s1_item_ff.pos_x) <<< 16) + 64'(s1_vxdt_ff) + RND16;
      s2_px1_in = sat32(pxs >>> 16);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_item_ff  <= s1_item_ff;
         s2_nrest_ff <= s1_nrest_ff;
         s2_onemf_ff <= s1_onemf_ff;
         s2_dvp_ff   <= s2_dvp_in;
         s2_px1_ff   <= s2_px1_in;
      end
   end

   // Stage 3: vertical velocity gains the rounded gravity increment.
   box_in_type         s3_item_ff;
   logic signed [17:0] s3_nrest_ff;
   logic [16:0]        s3_onemf_ff;
   logic signed [31:0] s3_px1_ff;
   logic signed [31:0] s3_vy1_ff, s3_vy1_in;
   logic signed [63:0] vys;

   always_comb begin
      vys       = (64'(s2_item_ff.vel_y) <<< SHIFT_G) + 64'(s2_dvp_ff) + RND_G;
      s3_vy1_in = sat32(vys >>> SHIFT_G);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_item_ff  <= s2_item_ff;
         s3_nrest_ff <= s2_nrest_ff;
         s3_onemf_ff <= s2_onemf_ff;
         s3_px1_ff   <= s2_px1_ff;
         s3_vy1_ff   <= s3_vy1_in;
      end
   end

   // Stage 4: vel_y times time step, side wall tests on the new x.
   box_in_type         s4_item_ff;
   logic signed [17:0] s4_nrest_ff;
   logic [16:0]        s4_onemf_ff;
   logic signed [31:0] s4_px1_ff;
   logic signed [31:0] s4_vy1_ff;
   logic signed [48:0] s4_vydt_ff, s4_vydt_in;
   logic               s4_left_ff, s4_left_in;
   logic               s4_right_ff, s4_right_in;
   logic signed [31:0] s4_wallx_ff, s4_wallx_in;
   logic signed [63:0] wall64, bw64;

   always_comb begin
      wall64      = $signed(64'(cfg.screen_width)) <<< FRAC_BITS;
      bw64        = $signed(64'(s3_item_ff.box_width));
      s4_vydt_in  = s3_vy1_ff * $signed({1'b0, cfg.time_step});
      s4_left_in  = s3_px1_ff <= 32'sd0;
      s4_right_in = (64'(s3_px1_ff) + bw64) >= wall64;
      s4_wallx_in = sat32(wall64 - bw64);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_item_ff  <= s3_item_ff;
         s4_nrest_ff <= s3_nrest_ff;
         s4_onemf_ff <= s3_onemf_ff;
         s4_px1_ff   <= s3_px1_ff;
         s4_vy1_ff   <= s3_vy1_ff;
         s4_vydt_ff  <= s4_vydt_in;
         s4_left_ff  <= s4_left_in;
         s4_right_ff <= s4_right_in;
         s4_wallx_ff <= s4_wallx_in;
      end
   end

   // Stage 5: new y position.
   integ_type          s5_data_ff, s5_data_in;
   logic signed [63:0] pys;

   always_comb begin
      pys                 = (64'(s4_item_ff.pos_y) <<< 16) + 64'(s4_vydt_ff) + RND16;
      s5_data_in.item     = s4_item_ff;
      s5_data_in.nrest    = s4_nrest_ff;
      s5_data_in.onemf    = s4_onemf_ff;
      s5_data_in.px1      = s4_px1_ff;
      s5_data_in.py1      = sat32(pys >>> 16);
      s5_data_in.vy1      = s4_vy1_ff;
      s5_data_in.at_left  = s4_left_ff;
      s5_data_in.at_right = s4_right_ff;
      s5_data_in.wall_x   = s4_wallx_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_data_ff <= s5_data_in;
      end
   end

   assign out_data = s5_data_ff;

endmodule

`default_nettype wire

[sv/bms_collide.sv]
// Stages six to ten: floor contact with bounce and friction, side wall bounce,
// and the pass-through of pinned boxes. Depends on bms_pkg.
`default_nettype none

module bms_collide
   import bms_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire cfg_type                            cfg,
   input  wire logic [PIPE_DEPTH-INTEG_STAGES-1:0] stage_en,
   input  wire integ_type                          in_data,
   output box_out_type                             out_data
);

   // Stage 6: floor test and clamp.
   integ_type          s6_d_ff;
   logic               s6_floor_ff, s6_floor_in;
   logic signed [31:0] s6_py2_ff, s6_py2_in;
   logic signed [63:0] floor64, bh64;

   always_comb begin
      floor64     = $signed(64'(cfg.screen_height)) <<< FRAC_BITS;
      bh64        = $signed(64'(in_data.item.box_height));
      s6_floor_in = (64'(in_data.py1) + bh64) >= floor64;
      s6_py2_in   = s6_floor_in ? sat32(floor64 - bh64) : in_data.py1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s6_d_ff     <= in_data;
         s6_floor_ff <= s6_floor_in;
         s6_py2_ff   <= s6_py2_in;
      end
   end

   // Stage 7: bounce and friction products.
   integ_type          s7_d_ff;
   logic               s7_floor_ff;
   logic signed [31:0] s7_py2_ff;
   logic signed [49:0] s7_vyb_ff, s7_vyb_in;
   logic signed [49:0] s7_vxf_ff, s7_vxf_in;

   always_comb begin
      s7_vyb_in = s6_d_ff.vy1 * s6_d_ff.nrest;
      s7_vxf_in = s6_d_ff.item.vel_x * $signed({1'b0, s6_d_ff.onemf});
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s7_d_ff     <= s6_d_ff;
         s7_floor_ff <= s6_floor_ff;
         s7_py2_ff   <= s6_py2_ff;
         s7_vyb_ff   <= s7_vyb_in;
         s7_vxf_ff   <= s7_vxf_in;
      end
   end

   // Stage 8: velocities after floor contact.
   integ_type          s8_d_ff;
   logic signed [31:0] s8_py2_ff;
   logic signed [31:0] s8_vx2_ff, s8_vx2_in;
   logic signed [31:0] s8_vy2_ff, s8_vy2_in;

   always_comb begin
      s8_vx2_in = s7_floor_ff ? round16_sat(64'(s7_vxf_ff)) : s7_d_ff.item.vel_x;
      s8_vy2_in = s7_floor_ff ? round16_sat(64'(s7_vyb_ff)) : s7_d_ff.vy1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s8_d_ff   <= s7_d_ff;
         s8_py2_ff <= s7_py2_ff;
         s8_vx2_ff <= s8_vx2_in;
         s8_vy2_ff <= s8_vy2_in;
      end
   end

   // Stage 9: wall bounce product.
   integ_type          s9_d_ff;
   logic signed [31:0] s9_py2_ff;
   logic signed [31:0] s9_vx2_ff;
   logic signed [31:0] s9_vy2_ff;
   logic signed [49:0] s9_vxw_ff, s9_vxw_in;

   assign s9_vxw_in = s8_vx2_ff * s8_d_ff.nrest;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s9_d_ff   <= s8_d_ff;
         s9_py2_ff <= s8_py2_ff;
         s9_vx2_ff <= s8_vx2_ff;
         s9_vy2_ff <= s8_vy2_ff;
         s9_vxw_ff <= s9_vxw_in;
      end
   end

   // Stage 10: wall clamp, pinned boxes keep their inputs.
   box_out_type s10_out_ff, s10_out_in;
   logic        wall_hit;

   always_comb begin
      wall_hit = s9_d_ff.at_left || s9_d_ff.at_right;
      if (s9_d_ff.item.pinned) begin
         s10_out_in.new_pos_x = s9_d_ff.item.pos_x;
         s10_out_in.new_pos_y = s9_d_ff.item.pos_y;
         s10_out_in.new_vel_x = s9_d_ff.item.vel_x;
         s10_out_in.new_vel_y = s9_d_ff.item.vel_y;
      end else begin
         s10_out_in.new_pos_y = s9_py2_ff;
         s10_out_in.new_vel_y = s9_vy2_ff;
         if (!wall_hit) begin
            s10_out_in.new_pos_x = s9_d_ff.px1;
            s10_out_in.new_vel_x = s9_vx2_ff;
         end else begin
            s10_out_in.new_pos_x = s9_d_ff.at_left ? 32'sd0 : s9_d_ff.wall_x;
            s10_out_in.new_vel_x = round16_sat(64'(s9_vxw_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s10_out_ff <= s10_out_in;
      end
   end

   assign out_data = s10_out_ff;

endmodule

`default_nettype wire
